### sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/itoa_pkg.sv
`default_nettype none
package itoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int POS_W      = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

endpackage
`default_nettype wire

### sv/itoa_dd_unit.sv
`default_nettype none
module itoa_dd_unit (
  input  wire itoa_pkg::bcd_t bcd_in,
  input  wire logic           bit_in,
  output itoa_pkg::bcd_t      bcd_out
);

  localparam int BCD_W = itoa_pkg::NUM_DIGITS * itoa_pkg::DIGIT_W;

  itoa_pkg::bcd_t   adj;
  logic [BCD_W-1:0] adj_bits;

  // add 3 to every digit of 5 or more, then shift in the next binary bit
  always_comb begin
    for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
      if (bcd_in[i] >= 4'd5) begin
        adj[i] = bcd_in[i] + 4'd3;
      end else begin
        adj[i] = bcd_in[i];
      end
    end
  end

  assign adj_bits = adj;
  assign bcd_out  = {adj_bits[BCD_W-2:0], bit_in};

endmodule
`default_nettype wire

### sv/signed_int_to_decimal_ascii.sv
`default_nettype none
`include "assert_macros.svh"
// Converts one signed 32-bit integer into its decimal ASCII text, most
// significant character first, with a leading '-' for negative values and no
// leading zeros. A transaction is taken when start is high while busy is low;
// busy then stays high until the final character has been sent. Each character
// appears for exactly one cycle with strobe high, and the receiver cannot stall
// it. After the accepting edge, busy stays high while the shared shift-add-3
// unit shifts in the magnitude (one binary bit per cycle), while leading zeros
// are scanned past, and while the characters (digits plus the sign) are sent
// back to back. The next transaction can be accepted once busy has fallen,
// in the idle state that follows the last character.
module signed_int_to_decimal_ascii (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [31:0]  value,
  output logic                     busy,
  output logic                     strobe,
  output logic [7:0]               char_code,
  output logic [3:0]               char_pos,
  output logic                     last_char
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                          state;
  logic [itoa_pkg::VALUE_W-1:0]    bin;
  itoa_pkg::bcd_t                  bcd;
  itoa_pkg::bcd_t                  bcd_next;
  logic                            neg;
  logic [itoa_pkg::CNT_W-1:0]      cnt;
  logic [itoa_pkg::IDX_W-1:0]      dig_idx;
  logic [itoa_pkg::POS_W-1:0]      pos;
  logic [itoa_pkg::DIGIT_W-1:0]    cur_digit;
  logic [itoa_pkg::VALUE_W-1:0]    mag;

  itoa_dd_unit u_dd (
    .bcd_in  (bcd),
    .bit_in  (bin[itoa_pkg::VALUE_W-1]),
    .bcd_out (bcd_next)
  );

  assign mag       = value[31] ? (~$unsigned(value) + 32'd1) : $unsigned(value);
  assign cur_digit = bcd[dig_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      dig_idx <= '0;
      pos     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            bin   <= mag;
            bcd   <= '0;
            neg   <= value[31];
            cnt   <= '0;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          bcd <= bcd_next;
          bin <= {bin[itoa_pkg::VALUE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == itoa_pkg::CNT_W'(itoa_pkg::VALUE_W - 1)) begin
            dig_idx <= itoa_pkg::IDX_W'(itoa_pkg::NUM_DIGITS - 1);
            state   <= S_SKIP;
          end
        end
        S_SKIP: begin
          pos <= '0;
          if (cur_digit == '0 && dig_idx != '0) begin
            dig_idx <= dig_idx - 1'b1;
          end else if (neg) begin
            state <= S_SIGN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_SIGN: begin
          pos   <= pos + 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          pos <= pos + 1'b1;
          if (dig_idx == '0) begin
            state <= S_IDLE;
          end else begin
            dig_idx <= dig_idx - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign strobe    = (state == S_SIGN) || (state == S_EMIT);
  assign char_code = (state == S_SIGN) ? itoa_pkg::ASCII_MINUS
                                       : (itoa_pkg::ASCII_ZERO | {4'd0, cur_digit});
  assign char_pos  = pos;
  assign last_char = (state == S_EMIT) && (dig_idx == '0);

  `ASSERT_SAME(a_strobe_busy, clk, rst, strobe, busy)
  `ASSERT_NEXT(a_last_idle, clk, rst, strobe && last_char, !busy)
  `ASSERT_NEXT(a_chars_contiguous, clk, rst, strobe && !last_char, strobe)
  `ASSERT_SAME(a_minus_first, clk, rst, strobe && char_code == itoa_pkg::ASCII_MINUS, char_pos == '0)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !strobe)

endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 70;

  typedef struct packed {
    logic [7:0] code;
    logic [3:0] pos;
    logic       last;
  } ascii_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] value = '0;
  logic        busy;
  logic        strobe;
  logic [7:0]  char_code;
  logic [3:0]  char_pos;
  logic        last_char;

  ascii_char_t pending_chars[$];
  int          mismatches = 0;
  int          idle_pct = 0;
  int          quiet_cycles = 0;

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .char_code (char_code),
    .char_pos  (char_pos),
    .last_char (last_char)
  );

  always #2 clk = ~clk;

  function automatic void predict_decimal_text(input logic [31:0] raw);
    logic [3:0]  digs [10];
    logic [31:0] mag;
    logic        neg;
    int          ndig;
    int          total;
    int          p;
    ascii_char_t ch;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;
    ndig = 0;
    do begin
      digs[ndig] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      ndig++;
    end while (mag != 0 && ndig < 10);
    total = ndig + (neg ? 1 : 0);
    p = 0;
    if (neg) begin
      ch.code = itoa_pkg::ASCII_MINUS;
      ch.pos  = 4'd0;
      ch.last = (total == 1);
      pending_chars.push_back(ch);
      p = 1;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.code = itoa_pkg::ASCII_ZERO + 8'(digs[k]);
      ch.pos  = 4'(p);
      ch.last = (p == total - 1);
      pending_chars.push_back(ch);
      p++;
    end
  endfunction

  // value with a random digit count and sign, or fully random bits
  function automatic logic [31:0] shaped_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int              len;
    bit              neg;
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    len = int'($urandom_range(10, 1));
    neg = 1'($urandom_range(1));
    lo = 1;
    for (int i = 1; i < len; i++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (len == 1) begin
      lo = 0;
    end
    if (hi > (neg ? 64'd2147483648 : 64'd2147483647)) begin
      hi = neg ? 64'd2147483648 : 64'd2147483647;
    end
    mag = lo + $urandom_range(32'(hi - lo), 0);
    return neg ? (32'd0 - 32'(mag)) : 32'(mag);
  endfunction

  task automatic send_value(input logic [31:0] v);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    predict_decimal_text(v);
  endtask

  task automatic test_directed_extremes();
    logic [31:0] vals [$];
    vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd9, -32'sd10,
             32'd99, 32'd100, -32'sd100, 32'd999_999_999, 32'd1_000_000_000,
             -32'sd999_999_999, -32'sd1_000_000_000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0001, 32'd1_234_567_890, 32'hAAAA_AAAA,
             32'h5555_5555, 32'd123_456_789, -32'sd7};
    idle_pct = 0;
    foreach (vals[i]) begin
      send_value(vals[i]);
    end
  endtask

  task automatic test_random_no_idle();
    idle_pct = 0;
    repeat (PHASE_ITEMS) send_value(shaped_value());
  endtask

  task automatic test_random_sender_idle();
    idle_pct = 49;
    repeat (PHASE_ITEMS) send_value(shaped_value());
  endtask

  task automatic test_random_light_idle();
    idle_pct = 10;
    repeat (PHASE_ITEMS) send_value(shaped_value());
  endtask

  task automatic test_random_mixed_idle();
    repeat (PHASE_ITEMS / 10) begin
      idle_pct = ($urandom_range(1) == 0) ? 0 : $urandom_range(60, 5);
      repeat (10) send_value(shaped_value());
    end
  endtask

  // result checking
  always @(posedge clk) begin
    ascii_char_t exp_ch;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        $display("%0t unexpected transaction: char_code %0d char_pos %0d last_char %0b",
                 $time, char_code, char_pos, last_char);
        mismatches++;
      end else begin
        exp_ch = pending_chars.pop_front();
        if (char_code !== exp_ch.code) begin
          $display("%0t char_code mismatch: expected %0d, actual %0d",
                   $time, exp_ch.code, char_code);
          mismatches++;
        end
        if (char_pos !== exp_ch.pos) begin
          $display("%0t char_pos mismatch: expected %0d, actual %0d",
                   $time, exp_ch.pos, char_pos);
          mismatches++;
        end
        if (last_char !== exp_ch.last) begin
          $display("%0t last_char mismatch: expected %0b, actual %0b",
                   $time, exp_ch.last, last_char);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t timeout with %0d characters outstanding", $time, pending_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_light_idle();
    test_random_mixed_idle();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
